// ===== sv/as_path_pattern_matcher_macros.svh =====
// Assertion macros for the AS path pattern matcher.
// Used by the top level only; no other dependencies.
`ifndef AS_PATH_PATTERN_MATCHER_MACROS_SVH
`define AS_PATH_PATTERN_MATCHER_MACROS_SVH

`ifndef SYNTH
`define APPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`define APPM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define APPM_ASSERT_NEXT(label, ante, cons, msg)
`define APPM_ASSERT_SAME(label, ante, cons, msg)
`endif

`endif

// ===== sv/appm_pkg.sv =====
// Shared types and constants of the AS path pattern matcher.
// Used by the controller, the datapath and the top level.
`default_nettype none

package appm_pkg;

    localparam logic [1:0] OP_PATH = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    localparam logic [1:0] MODE_ANY    = 2'd0;
    localparam logic [1:0] MODE_STARTS = 2'd1;
    localparam logic [1:0] MODE_ENDS   = 2'd2;
    localparam logic [1:0] MODE_EXACT  = 2'd3;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_LEN  = 1'b1;

    typedef struct packed {
        logic take_path;
        logic take_load;
        logic scan_init;
        logic scan_step;
        logic finish_path;
        logic finish_end;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic scan_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== sv/appm_ctrl.sv =====
// Controller state machine of the AS path pattern matcher.
// Depends on appm_pkg; drives the datapath through command and status structs.
`default_nettype none

module appm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [1:0]      i_opcode,
    output logic                 o_ready,
    input  wire appm_pkg::t_status i_status,
    output appm_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_is_end, n_is_end;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_is_end = r_is_end;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    priority if (i_opcode == appm_pkg::OP_PATH) begin
                        o_cmd.take_path = 1'b1;
                        o_cmd.scan_init = 1'b1;
                        n_is_end        = 1'b0;
                        n_state         = i_status.len_zero ? S_DONE : S_SCAN;
                    end else if (i_opcode == appm_pkg::OP_END) begin
                        o_cmd.scan_init = 1'b1;
                        n_is_end        = 1'b1;
                        n_state         = i_status.len_zero ? S_DONE : S_SCAN;
                    end else if (i_opcode == appm_pkg::OP_LOAD) begin
                        o_cmd.take_load = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_is_end) begin
                    o_cmd.finish_path = 1'b1;
                    n_state           = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.finish_end = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_is_end <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_is_end <= n_is_end;
        end
    end

endmodule

`default_nettype wire

// ===== sv/appm_dp.sv =====
// Datapath of the AS path pattern matcher: pattern store, path window,
// path flags, one shared slot comparator and the result register. Uses appm_pkg.
`default_nettype none

module appm_dp #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire appm_pkg::t_cmd    i_cmd,
    output appm_pkg::t_status      o_status,
    input  wire logic [31:0]       i_as_number,
    input  wire logic [3:0]        i_pattern_index,
    input  wire logic              i_wildcard_req,
    input  wire logic [1:0]        i_match_mode,
    input  wire logic [4:0]        i_pattern_length,
    input  wire logic              i_m_tready,
    output logic                   o_m_tvalid,
    output logic                   o_matched
);

    localparam int PAT_SLOTS = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;
    localparam int SW = (PAT_SLOTS > 1) ? $clog2(PAT_SLOTS) : 1;
    localparam int LW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW = $clog2(MAX_PATTERN + 2);
    localparam int EW = $clog2(MAX_PATTERN + 1);
    localparam logic [7:0] MAX8   = 8'(MAX_PATTERN);
    localparam logic [7:0] SAT8   = 8'(MAX_PATTERN + 1);
    localparam logic [7:0] SLOTS8 = 8'(PAT_SLOTS);
    localparam logic [4:0] SLOTS5 = 5'(PAT_SLOTS);

    logic [31:0]   r_pval [PAT_SLOTS];
    logic          r_pwild [PAT_SLOTS];
    logic [31:0]   r_window [MAX_PATTERN];
    logic [CW-1:0] r_count;
    logic          r_prefix_ok;
    logic          r_found;
    logic          r_suf_ok;
    logic [LW-1:0] r_j;
    logic          r_out_valid;
    logic          r_matched;

    logic [7:0]    w_plen8;
    logic [7:0]    w_eff8;
    logic [EW-1:0] w_len;
    logic [7:0]    w_len8;
    logic [7:0]    w_count8;
    logic [CW-1:0] w_cnt_inc;
    logic [CW-1:0] w_cnt_after;
    logic [7:0]    w_rd_slot8;
    logic [7:0]    w_win_idx8;
    logic [31:0]   w_rd_data;
    logic          w_acc;
    logic          w_result;

    assign w_plen8  = 8'(i_pattern_length);
    assign w_eff8   = (w_plen8 > MAX8) ? MAX8 : w_plen8;
    assign w_len    = w_eff8[EW-1:0];
    assign w_len8   = 8'(w_len);
    assign w_count8 = 8'(r_count);

    assign w_cnt_inc   = (w_count8 < SAT8) ? r_count + CW'(1) : r_count;
    assign w_cnt_after = i_cmd.take_path ? w_cnt_inc : r_count;

    // One slot compare per cycle: the prefix slot when a path entry arrives,
    // otherwise the scan slot against its window entry.
    assign w_rd_slot8 = i_cmd.take_path ? w_count8 : 8'(r_j);
    assign w_win_idx8 = w_len8 - 8'd1 - 8'(r_j);
    assign w_rd_data  = i_cmd.take_path ? i_as_number : r_window[w_win_idx8[LW-1:0]];

    always_comb begin
        if (w_rd_slot8 < SLOTS8) begin
            w_acc = r_pwild[w_rd_slot8[SW-1:0]] || (r_pval[w_rd_slot8[SW-1:0]] == w_rd_data);
        end else begin
            w_acc = (w_rd_data == 32'd0);
        end
    end

    always_comb begin
        unique case (i_match_mode)
            appm_pkg::MODE_ANY:    w_result = r_found || r_suf_ok;
            appm_pkg::MODE_STARTS: w_result = r_prefix_ok && (w_count8 >= w_len8);
            appm_pkg::MODE_ENDS:   w_result = r_suf_ok;
            appm_pkg::MODE_EXACT:  w_result = r_prefix_ok && (w_count8 == w_len8);
            default:               w_result = 1'b0;
        endcase
    end

    assign o_status.len_zero  = (w_len8 == 8'd0);
    assign o_status.scan_last = (8'(r_j) == (w_len8 - 8'd1));
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_matched  = r_matched;

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_load && ({1'b0, i_pattern_index} < SLOTS5)) begin
            r_pval[i_pattern_index[SW-1:0]]  <= i_as_number;
            r_pwild[i_pattern_index[SW-1:0]] <= i_wildcard_req;
        end
        if (i_cmd.take_path) begin
            r_window[0] <= i_as_number;
            for (int k = 1; k < MAX_PATTERN; k++) begin
                r_window[k] <= r_window[k-1];
            end
        end
        if (i_cmd.scan_init) begin
            r_suf_ok <= (8'(w_cnt_after) >= w_len8);
            r_j      <= '0;
        end else if (i_cmd.scan_step) begin
            r_suf_ok <= r_suf_ok && w_acc;
            r_j      <= r_j + LW'(1);
        end
        if (i_cmd.finish_end) begin
            r_matched <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_prefix_ok <= 1'b1;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.take_path) begin
                r_count <= w_cnt_inc;
                if ((w_count8 < w_len8) && !w_acc) begin
                    r_prefix_ok <= 1'b0;
                end
            end
            if (i_cmd.finish_path && r_suf_ok) begin
                r_found <= 1'b1;
            end
            if (i_cmd.finish_end) begin
                r_count     <= '0;
                r_prefix_ok <= 1'b1;
                r_found     <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/as_path_pattern_matcher.sv =====
// Top level of the AS path pattern matcher: register port, stream ports,
// controller and datapath. Depends on appm_pkg, appm_ctrl, appm_dp and the macro header.
//
// Channel   Direction  Request carries
// s_*       in         one path entry, end of path, pattern load or ignored code
// m_*       out        match bit of a completed path
// APB       in/out     match_mode at 0x0, pattern_length at 0x4
//
// A path entry or end of path scans L slots, L being pattern_length capped
// at MAX_PATTERN: one slot is compared per cycle by the single shared comparator.
// A pattern load or an unknown code is taken while idle. Reset is synchronous and
// clears the path state and the output; pattern slots hold nothing until loaded.
// An end of path waits in its last cycle while a previous result is not taken.
`default_nettype none
`include "as_path_pattern_matcher_macros.svh"

module as_path_pattern_matcher #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // as_number[31:0], pattern_index[35:32],
                                        // wildcard_req[36], zero[39:37]
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // matched[0], zero[7:1]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [1:0] r_mode;
    logic [4:0] r_plen;

    appm_pkg::t_cmd    w_cmd;
    appm_pkg::t_status w_status;
    logic              w_matched;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == appm_pkg::REG_LEN) ? {27'd0, r_plen} : {30'd0, r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= appm_pkg::MODE_ANY;
            r_plen <= 5'd0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == appm_pkg::REG_MODE) begin
                r_mode <= pwdata[1:0];
            end else begin
                r_plen <= pwdata[4:0];
            end
        end
    end

    appm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_tvalid),
        .i_opcode (s_tuser),
        .o_ready  (s_tready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    appm_dp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_as_number      (s_tdata[31:0]),
        .i_pattern_index  (s_tdata[35:32]),
        .i_wildcard_req   (s_tdata[36]),
        .i_match_mode     (r_mode),
        .i_pattern_length (r_plen),
        .i_m_tready       (m_tready),
        .o_m_tvalid       (m_tvalid),
        .o_matched        (w_matched)
    );

    assign m_tdata = {7'd0, w_matched};

    `APPM_ASSERT_NEXT(a_end_blocks_input, s_tvalid && s_tready && (s_tuser == appm_pkg::OP_END), !s_tready, "end of path request did not start a scan")
    `APPM_ASSERT_NEXT(a_load_one_cycle, s_tvalid && s_tready && (s_tuser == appm_pkg::OP_LOAD), s_tready, "pattern load request took more than one cycle")
    `APPM_ASSERT_SAME(a_out_padding, m_tvalid, m_tdata[7:1] == 7'd0, "result padding bits are not zero")

endmodule

`default_nettype wire
